### hdl/sbss_pkg.sv
// ----------------------------------------------------------------------------
// sbss_pkg
// Shared widths, reset values, codes and segment tables for the scaled BCD
// seven-segment scanner.
// ----------------------------------------------------------------------------
package sbss_pkg;

  // Field widths
  localparam int SAMPLE_W  = 8;
  localparam int SCALE_W   = 6;
  localparam int DWELL_W   = 8;
  localparam int VALUE_W   = 14;
  localparam int SEG_W     = 8;
  localparam int LINE_W    = 4;
  localparam int BCD_W     = 4;
  localparam int POS_COUNT = 4;
  localparam int REG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // Default number of scanned digit positions
  localparam int DIGIT_COUNT_DEF = 4;

  // Reset values and limits
  localparam logic [SCALE_W-1:0] SCALE_RST  = 6'd19;
  localparam logic [DWELL_W-1:0] DWELL_RST  = 8'd100;
  localparam logic [VALUE_W-1:0] VALUE_MAX  = 14'd9999;
  localparam logic [SEG_W-1:0]   SEG_BLANK  = 8'hFF;
  localparam logic [LINE_W-1:0]  LINE_BLANK = 4'hF;

  // Input word kinds
  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_TICK   = 1'b1
  } action_t;

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCALE = 1'b0,
    REG_DWELL = 1'b1
  } reg_idx_t;

  // Decimal digits, position 0 is thousands, position 3 is units
  typedef logic [BCD_W-1:0] digit_t;
  typedef digit_t [POS_COUNT-1:0] bcd_t;

  // Active-low common-anode code, decimal point off
  function automatic logic [SEG_W-1:0] seg_code(input digit_t d);
    logic [SEG_W-1:0] code;
    case (d)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      default: code = 8'h90;   // nine, and clamp anything above
    endcase
    return code;
  endfunction

  // Active-low digit enable for a position, bit 3 thousands to bit 0 units
  function automatic logic [LINE_W-1:0] line_code(input logic [1:0] pos);
    logic [LINE_W-1:0] code;
    case (pos)
      2'd0:    code = 4'h7;
      2'd1:    code = 4'hB;
      2'd2:    code = 4'hD;
      default: code = 4'hE;
    endcase
    return code;
  endfunction

endpackage

### hdl/sbss_if.sv
// ----------------------------------------------------------------------------
// sbss channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface sbss_in_if;
  logic                              valid;
  logic                              ready;
  logic                              action;
  logic [sbss_pkg::SAMPLE_W-1:0]     adc_sample;

  modport source(output valid, action, adc_sample, input ready);
  modport sink(input valid, action, adc_sample, output ready);
endinterface

interface sbss_out_if;
  logic                              valid;
  logic                              ready;
  logic [sbss_pkg::SEG_W-1:0]        segments;
  logic [sbss_pkg::LINE_W-1:0]       digit_lines;

  modport source(output valid, segments, digit_lines, input ready);
  modport sink(input valid, segments, digit_lines, output ready);
endinterface

interface sbss_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sbss_pkg::REG_IDX_W-1:0]    index;
  logic [sbss_pkg::CFG_W-1:0]        data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### hdl/scaled_bcd_seven_segment_scanner.sv
// ----------------------------------------------------------------------------
// scaled_bcd_seven_segment_scanner
// Scales converter samples, scans the latched value over the digit positions
// and returns the segment byte and digit lines after every input word.
//
//   channel   | dir | payload                        | handshake
//   ----------+-----+--------------------------------+------------
//   in_chan   | in  | action, adc_sample             | valid/ready
//   out_chan  | out | segments, digit_lines          | valid/ready
//   cfg_chan  | in  | index, data                    | valid/ready
//
// One word per cycle sustained while the receiver takes results; a result
// passes through the input register, then the result register.
// The scale multiply and the digit select sit between those two registers.
// Synchronous active-low reset clears the scan state, the stored values and
// both pipeline valids; the configuration registers return to their reset values.
// A stalled result holds its register; the input register still takes a word
// while the result register can drain in the same cycle.
// Register writes are always ready and take effect at the next edge.
// ----------------------------------------------------------------------------
module scaled_bcd_seven_segment_scanner #(
  parameter int DIGIT_COUNT = sbss_pkg::DIGIT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  sbss_in_if.sink       in_chan,
  sbss_out_if.source    out_chan,
  sbss_cfg_if.sink      cfg_chan
);

  localparam int PHASES  = 2 * DIGIT_COUNT;
  localparam int PHASE_W = $clog2(PHASES);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(PHASES - 1);
  localparam logic [1:0]         POS_BASE   = 2'(sbss_pkg::POS_COUNT - DIGIT_COUNT);

  // Configuration registers
  logic [sbss_pkg::SCALE_W-1:0]  scale_r;
  logic [sbss_pkg::DWELL_W-1:0]  dwell_r;

  // Input register
  logic                          item_valid_r;
  logic                          action_r;
  logic [sbss_pkg::SAMPLE_W-1:0] sample_r;

  // Block state
  logic [sbss_pkg::VALUE_W-1:0]  scaled_r, scaled_nxt;
  sbss_pkg::bcd_t                frame_bcd_r, frame_bcd_nxt;
  logic [PHASE_W-1:0]            phase_r, phase_nxt;
  logic [sbss_pkg::DWELL_W-1:0]  count_r, count_nxt;

  // Result register
  logic                          out_valid_r;
  logic [sbss_pkg::SEG_W-1:0]    seg_r, seg_nxt;
  logic [sbss_pkg::LINE_W-1:0]   lines_r, lines_nxt;

  logic                          load_out;
  logic                          in_acc;
  logic [sbss_pkg::VALUE_W-1:0]  product;
  logic [sbss_pkg::DWELL_W-1:0]  count_inc;
  logic [PHASE_W-1:0]            phase_adv;
  logic [1:0]                    pos;
  sbss_pkg::bcd_t                scaled_bcd;

  // Handshakes
  assign load_out      = item_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !item_valid_r || load_out;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= sbss_pkg::SCALE_RST;
      dwell_r <= sbss_pkg::DWELL_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        sbss_pkg::REG_SCALE: scale_r <= cfg_chan.data[sbss_pkg::SCALE_W-1:0];
        sbss_pkg::REG_DWELL: dwell_r <= cfg_chan.data[sbss_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture input word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      item_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_chan.action;
      sample_r <= in_chan.adc_sample;
    end
  end

  // Digits of the stored value, ready for a frame start
  sbss_bcd_split u_bcd_split (
    .value  (scaled_r),
    .digits (scaled_bcd)
  );

  // Scale, saturate and advance the scan
  assign product   = sbss_pkg::VALUE_W'(sample_r) * sbss_pkg::VALUE_W'(scale_r);
  assign count_inc = count_r + 1'b1;
  assign phase_adv = (phase_r == PHASE_LAST) ? '0 : phase_r + 1'b1;

  always_comb begin
    scaled_nxt    = scaled_r;
    frame_bcd_nxt = frame_bcd_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    if (load_out) begin
      if (action_r == sbss_pkg::ACT_SAMPLE) begin
        scaled_nxt = (product > sbss_pkg::VALUE_MAX) ? sbss_pkg::VALUE_MAX : product;
      end else if (count_inc >= dwell_r) begin
        count_nxt = '0;
        phase_nxt = phase_adv;
        if (phase_adv == '0) begin
          frame_bcd_nxt = scaled_bcd;
        end
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  // Encode the display for the state after the word
  assign pos = POS_BASE + 2'(phase_nxt >> 1);

  always_comb begin
    if (phase_nxt[0]) begin
      seg_nxt   = sbss_pkg::SEG_BLANK;
      lines_nxt = sbss_pkg::LINE_BLANK;
    end else begin
      seg_nxt   = sbss_pkg::seg_code(frame_bcd_nxt[pos]);
      lines_nxt = sbss_pkg::line_code(pos);
    end
  end

  // Hold block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scaled_r    <= '0;
      frame_bcd_r <= '0;
      phase_r     <= '0;
      count_r     <= '0;
    end else begin
      scaled_r    <= scaled_nxt;
      frame_bcd_r <= frame_bcd_nxt;
      phase_r     <= phase_nxt;
      count_r     <= count_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      seg_r   <= seg_nxt;
      lines_r <= lines_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.segments    = seg_r;
  assign out_chan.digit_lines = lines_r;

endmodule

### hdl/sbss_bcd_split.sv
// ----------------------------------------------------------------------------
// sbss_bcd_split
// Splits a value of at most 9999 into four decimal digits. Quotients by
// 1000, 100 and 10 come from reciprocal multiplies in parallel; each digit
// is a quotient minus ten times the next coarser one.
// ----------------------------------------------------------------------------
module sbss_bcd_split (
  input  logic [sbss_pkg::VALUE_W-1:0] value,
  output sbss_pkg::bcd_t               digits
);

  // Reciprocals, exact for every value up to 9999
  localparam int R1000_W = 14;
  localparam int R100_W  = 13;
  localparam int R10_W   = 13;
  localparam logic [R1000_W-1:0] R1000 = 14'd8389;   // 2^23 / 1000, rounded up
  localparam logic [R100_W-1:0]  R100  = 13'd5243;   // 2^19 / 100, rounded up
  localparam logic [R10_W-1:0]   R10   = 13'd6554;   // 2^16 / 10, rounded up
  localparam int S1000 = 23;
  localparam int S100  = 19;
  localparam int S10   = 16;

  localparam int P1000_W = sbss_pkg::VALUE_W + R1000_W;
  localparam int P100_W  = sbss_pkg::VALUE_W + R100_W;
  localparam int P10_W   = sbss_pkg::VALUE_W + R10_W;

  logic [P1000_W-1:0] prod_1000;
  logic [P100_W-1:0]  prod_100;
  logic [P10_W-1:0]   prod_10;
  logic [3:0]         quo_1000;
  logic [6:0]         quo_100;
  logic [9:0]         quo_10;

  // Quotients
  assign prod_1000 = P1000_W'(value) * P1000_W'(R1000);
  assign prod_100  = P100_W'(value) * P100_W'(R100);
  assign prod_10   = P10_W'(value) * P10_W'(R10);

  assign quo_1000 = 4'(prod_1000 >> S1000);
  assign quo_100  = 7'(prod_100 >> S100);
  assign quo_10   = 10'(prod_10 >> S10);

  // Digits
  assign digits[0] = quo_1000;
  assign digits[1] = 4'(quo_100 - 7'(quo_1000) * 7'd10);
  assign digits[2] = 4'(quo_10 - 10'(quo_100) * 10'd10);
  assign digits[3] = 4'(value - 14'(quo_10) * 14'd10);

endmodule

### test/scaled_bcd_seven_segment_scanner_tb.sv
// ----------------------------------------------------------------------------
// scaled_bcd_seven_segment_scanner_tb
// Drives sample and tick words through the scanner with bursty input and a
// stalling receiver, writes both registers between phases, and checks every
// segment byte and digit-line word against a cycle-free scan predictor.
// ----------------------------------------------------------------------------
module scaled_bcd_seven_segment_scanner_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS    = sbss_pkg::DIGIT_COUNT_DEF;
  localparam int PHASES    = 2 * DIGITS;
  localparam int RAND_PHASES = 9;
  localparam int RAND_WORDS  = 100;

  typedef struct packed {
    sbss_pkg::action_t              action;
    logic [sbss_pkg::SAMPLE_W-1:0]  sample;
  } scan_word_t;

  typedef struct packed {
    logic [sbss_pkg::SEG_W-1:0]   segments;
    logic [sbss_pkg::LINE_W-1:0]  lines;
  } display_t;

  // Own copy of the common-anode digit codes and digit enables
  localparam logic [sbss_pkg::SEG_W-1:0] DIGIT_SEGS [10] = '{
    8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
  };
  localparam logic [sbss_pkg::LINE_W-1:0] POS_LINES [4] = '{4'h7, 4'hB, 4'hD, 4'hE};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbss_in_if  in_if();
  sbss_out_if out_if();
  sbss_cfg_if cfg_if();

  // Local drive registers, known from time zero
  logic                          in_valid_q  = 1'b0;
  logic                          in_action_q = 1'b0;
  logic [sbss_pkg::SAMPLE_W-1:0] in_sample_q = '0;
  logic                          out_ready_q = 1'b0;
  logic                          cfg_valid_q = 1'b0;
  logic [sbss_pkg::REG_IDX_W-1:0] cfg_index_q = '0;
  logic [sbss_pkg::CFG_W-1:0]    cfg_data_q  = '0;

  assign in_if.valid      = in_valid_q;
  assign in_if.action     = in_action_q;
  assign in_if.adc_sample = in_sample_q;
  assign out_if.ready     = out_ready_q;
  assign cfg_if.valid     = cfg_valid_q;
  assign cfg_if.index     = cfg_index_q;
  assign cfg_if.data      = cfg_data_q;

  scaled_bcd_seven_segment_scanner u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  scan_word_t word_queue[$];
  display_t   display_due[$];
  int         err_count = 0;

  // Predicted scanner state and registers
  logic [sbss_pkg::SCALE_W-1:0] scale_reg;
  logic [sbss_pkg::DWELL_W-1:0] dwell_reg;
  logic [sbss_pkg::VALUE_W-1:0] scaled_val;
  logic [sbss_pkg::VALUE_W-1:0] frame_val;
  logic [2:0]                   scan_ph;
  logic [sbss_pkg::DWELL_W-1:0] dwell_cnt;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    err_count++;
  endtask

  // Apply one word to the predicted state and return the display after it
  function automatic display_t scanner_next(input scan_word_t w);
    int unsigned prod;
    int unsigned d;
    logic [sbss_pkg::DWELL_W-1:0] nxt;
    logic [1:0] pos;
    display_t res;
    if (w.action == sbss_pkg::ACT_SAMPLE) begin
      prod = 32'(w.sample) * 32'(scale_reg);
      scaled_val = (prod > sbss_pkg::VALUE_MAX) ? sbss_pkg::VALUE_MAX
                                                : prod[sbss_pkg::VALUE_W-1:0];
    end else begin
      nxt = dwell_cnt + 1'b1;
      if (nxt >= dwell_reg) begin
        dwell_cnt = '0;
        scan_ph = 3'((scan_ph + 3'd1) % PHASES);
        if (scan_ph == 3'd0) frame_val = scaled_val;
      end else begin
        dwell_cnt = nxt;
      end
    end
    if (scan_ph[0]) begin
      res.segments = sbss_pkg::SEG_BLANK;
      res.lines    = sbss_pkg::LINE_BLANK;
    end else begin
      pos = 2'(4 - DIGITS + (scan_ph >> 1));
      case (pos)
        2'd0:    d = frame_val / 1000;
        2'd1:    d = (frame_val / 100) % 10;
        2'd2:    d = (frame_val / 10) % 10;
        default: d = frame_val % 10;
      endcase
      if (d > 9) d = 9;
      res.segments = DIGIT_SEGS[d];
      res.lines    = POS_LINES[pos];
    end
    return res;
  endfunction

  // Sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    scan_word_t w;
    if (!rst_n) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || in_if.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_q <= 1'b0;
      end else if (word_queue.size() > 0) begin
        w = word_queue.pop_front();
        in_valid_q  <= 1'b1;
        in_action_q <= w.action;
        in_sample_q <= w.sample;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_q <= 1'b0;
      end
    end
  end

  // Receiver: picks a random stall mode and holds it for a random run
  int stall_mode = 0;
  int mode_left = 0;
  logic [7:0] cyc = '0;

  always @(posedge clk) begin
    cyc <= cyc + 1'b1;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(10, 80);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_ready_q <= 1'b1;
      1:       out_ready_q <= 1'($urandom_range(0, 1));
      2:       out_ready_q <= ($urandom_range(0, 3) == 0);
      default: out_ready_q <= (cyc[2:0] != 3'd0) && (cyc[2:0] != 3'd5);
    endcase
  end

  // Monitor: track register writes, predict accepted words, check results
  always @(posedge clk) begin
    display_t want;
    if (!rst_n) begin
      scale_reg  = sbss_pkg::SCALE_RST;
      dwell_reg  = sbss_pkg::DWELL_RST;
      scaled_val = '0;
      frame_val  = '0;
      scan_ph    = '0;
      dwell_cnt  = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (sbss_pkg::reg_idx_t'(cfg_if.index) == sbss_pkg::REG_SCALE)
          scale_reg = cfg_if.data[sbss_pkg::SCALE_W-1:0];
        else dwell_reg = cfg_if.data[sbss_pkg::DWELL_W-1:0];
      end
      if (in_if.valid && in_if.ready)
        display_due.push_back(scanner_next({sbss_pkg::action_t'(in_if.action),
                                            in_if.adc_sample}));
      if (out_if.valid && out_if.ready) begin
        if (display_due.size() == 0) begin
          report_mismatch("unexpected word", int'({out_if.segments, out_if.digit_lines}), 0);
        end else begin
          want = display_due.pop_front();
          if (out_if.segments !== want.segments)
            report_mismatch("segments", int'(out_if.segments), int'(want.segments));
          if (out_if.digit_lines !== want.lines)
            report_mismatch("digit_lines", int'(out_if.digit_lines), int'(want.lines));
        end
      end
    end
  end

  // Hold until every queued word is sent and answered, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (word_queue.size() != 0 || in_valid_q || display_due.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input sbss_pkg::reg_idx_t idx,
                           input logic [sbss_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q  <= data;
    do @(posedge clk);
    while (!cfg_if.ready);
    cfg_valid_q <= 1'b0;
  endtask

  task automatic push_word(input sbss_pkg::action_t act,
                           input logic [sbss_pkg::SAMPLE_W-1:0] s);
    word_queue.push_back({act, s});
  endtask

  // Mostly ticks so the scan moves, samples biased toward the extremes
  task automatic push_random_words(input int n);
    logic [sbss_pkg::SAMPLE_W-1:0] s;
    int pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        push_word(sbss_pkg::ACT_TICK, 8'($urandom));
      end else begin
        pick = $urandom_range(0, 7);
        s = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        push_word(sbss_pkg::ACT_SAMPLE, s);
      end
    end
  endtask

  initial begin
    int scale_plan [RAND_PHASES] = '{0, 39, 63, 1, 19, -1, 40, -1, 39};
    int dwell_plan [RAND_PHASES] = '{255, 1, 0, 3, 255, 2, -1, 1, 0};
    logic [sbss_pkg::SCALE_W-1:0] sc;
    logic [sbss_pkg::DWELL_W-1:0] dw;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: samples at both ends, ticks that stay in the first phase
    push_word(sbss_pkg::ACT_SAMPLE, 8'h00);
    push_word(sbss_pkg::ACT_SAMPLE, 8'hFF);
    push_word(sbss_pkg::ACT_TICK, 8'h00);
    push_word(sbss_pkg::ACT_TICK, 8'hFF);
    wait_idle();

    // Saturation: full sample at the top scale, then a whole frame and a scan
    write_reg(sbss_pkg::REG_SCALE, 8'hFF);
    write_reg(sbss_pkg::REG_DWELL, 8'd1);
    @(negedge clk);
    push_word(sbss_pkg::ACT_SAMPLE, 8'hFF);
    repeat (16) push_word(sbss_pkg::ACT_TICK, 8'h5A);
    wait_idle();

    // Random phases, including a dwell drop below the running count
    for (int k = 0; k < RAND_PHASES; k++) begin
      sc = (scale_plan[k] < 0) ? 6'($urandom) : 6'(scale_plan[k]);
      dw = (dwell_plan[k] < 0) ? 8'($urandom_range(1, 6)) : 8'(dwell_plan[k]);
      write_reg(sbss_pkg::REG_SCALE, {2'($urandom), sc});
      write_reg(sbss_pkg::REG_DWELL, dw);
      @(negedge clk);
      push_random_words(RAND_WORDS);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (display_due.size() != 0)
      report_mismatch("words never returned", display_due.size(), 0);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
hdl/sbss_pkg.sv
hdl/sbss_if.sv
hdl/sbss_bcd_split.sv
hdl/scaled_bcd_seven_segment_scanner.sv
test/scaled_bcd_seven_segment_scanner_tb.sv
